FILE: rtl/core/altb_pkg.sv
// ----------------------------------------------------------------------------
// altb_pkg
// Shared constants, types and the log2 fraction table for the ambient light
// to brightness block.
// ----------------------------------------------------------------------------
package altb_pkg;

   // Default fixed-point formats.
   localparam int LUX_FRAC_BITS  = 8;
   localparam int LOG_TABLE_BITS = 6;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_ADDR_W-1:0] CSR_FILTER_ALPHA     = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_LUX          = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_LUX          = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_BRIGHTNESS_FLOOR = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_BRIGHTNESS_CAP   = 3'd4;

   localparam logic [16:0] ALPHA_RESET = 17'd6554;
   localparam logic [16:0] ALPHA_ONE   = 17'd65536;
   localparam logic [15:0] MIN_RESET   = 16'd1;
   localparam logic [15:0] MAX_RESET   = 16'd1000;
   localparam logic [7:0]  FLOOR_RESET = 8'd10;
   localparam logic [7:0]  CAP_RESET   = 8'd153;

   // Shared multiplier and the reciprocal of three used for the divide by six.
   localparam int          MUL_W        = 32;
   localparam logic [31:0] RECIP3       = 32'hAAAA_AAAB;
   localparam int          RECIP3_SHIFT = 33;

   // Rounding constant of the moving average (one half in Q0.16).
   localparam logic [15:0] EMA_HALF = 16'h8000;

   // Quotient bits of the brightness division.
   localparam int QUOT_W = 8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RECIP,
      ST_MUL_NEW,
      ST_MUL_OLD,
      ST_EMA,
      ST_LOG_LO,
      ST_LOG_HI,
      ST_LOG_V,
      ST_MUL_RANGE,
      ST_DIV,
      ST_OUT
   } state_type;

   // log2(1 + i / 2^tbits) in Q0.16, by repeated squaring of a Q1.30 mantissa.
   function automatic logic [15:0] log_table_entry(input int unsigned tbits,
                                                   input int unsigned i);
      longint unsigned m;
      logic [15:0]     frac;
      m    = ((64'd1 << tbits) + 64'(i)) << (30 - tbits);
      frac = '0;
      for (int k = 0; k < 16; k++) begin
         m    = (m * m) >> 30;
         frac = {frac[14:0], 1'b0};
         if (m >= (64'd1 << 31)) begin
            frac[0] = 1'b1;
            m       = m >> 1;
         end
      end
      return frac;
   endfunction

endpackage

FILE: rtl/core/altb_log2.sv
// ----------------------------------------------------------------------------
// altb_log2
// Iterative log2 unit: binary-search normalization, then a fraction table.
// ----------------------------------------------------------------------------
module altb_log2 #(
   parameter int VALUE_W    = 24,
   parameter int TABLE_BITS = 6
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start_i,
   input  logic [VALUE_W-1:0]                 value_i,
   output logic                               done_o,
   output logic [$clog2(VALUE_W)+16-1:0]      log_o
);

   localparam int STEPS  = $clog2(VALUE_W);
   localparam int STEP_W = $clog2(STEPS);
   localparam int TBL    = 1 << TABLE_BITS;

   logic [VALUE_W-1:0]    norm_ff, norm_in;
   logic [STEPS-1:0]      shift_ff, shift_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [STEPS-1:0]      shift_amt;
   logic [VALUE_W-1:0]    top_mask;
   logic                  top_zero;
   logic [STEPS-1:0]      lead_pos;
   logic [TABLE_BITS-1:0] idx;
   logic [15:0]           frac_tbl [TBL];

   for (genvar i = 0; i < TBL; i++) begin : g_tbl
      assign frac_tbl[i] = altb_pkg::log_table_entry(TABLE_BITS, i);
   end

   // Each step tests the top 2^step bits and shifts them out when all clear.
   assign shift_amt = STEPS'(1) << step_ff;
   assign top_mask  = ~({VALUE_W{1'b1}} >> shift_amt);
   assign top_zero  = ((norm_ff & top_mask) == '0);

   always_comb begin
      norm_in  = norm_ff;
      shift_in = shift_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start_i) begin
         norm_in  = value_i;
         shift_in = '0;
         step_in  = STEP_W'(STEPS - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (top_zero) begin
            norm_in  = norm_ff << shift_amt;
            shift_in = shift_ff | shift_amt;
         end
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      norm_ff  <= norm_in;
      shift_ff <= shift_in;
      step_ff  <= step_in;
   end

   // Bits just below the leading one, zero-filled by the normalizing shifts.
   assign lead_pos = STEPS'(VALUE_W - 1) - shift_ff;
   assign idx      = norm_ff[VALUE_W-2 -: TABLE_BITS];
   assign log_o    = {lead_pos, frac_tbl[idx]};
   assign done_o   = done_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start_i |-> !busy_ff)
      else $error("log2 unit started while busy");

   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && !$past(done_ff))
      else $error("log2 unit done pulse malformed");

   a_busy_len: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> step_ff == STEP_W'(STEPS - 1))
      else $error("log2 unit step count not loaded");

endmodule

FILE: rtl/core/ambient_lux_to_brightness.sv
// ----------------------------------------------------------------------------
// ambient_lux_to_brightness
// Light-sensor count to display brightness through a smoothed log mapping.
// ----------------------------------------------------------------------------
// An accepted word passes the reciprocal and average multiplies, the
//   average update, three log2 passes of S = ceil(log2(16+LUX_FRAC_BITS))
//   steps each, the range multiply and the eight-step division; rsp_tvalid
//   then rises once the output register is free. A new word is taken only
//   after the last is in the output register, since one sequencer runs all.
// Reset: synchronous, active high; loads register defaults and clears the
//   average to zero (unseeded) and the output valid.
// ----------------------------------------------------------------------------
module ambient_lux_to_brightness #(
   parameter int LUX_FRAC_BITS  = altb_pkg::LUX_FRAC_BITS,
   parameter int LOG_TABLE_BITS = altb_pkg::LOG_TABLE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input stream. tdata: raw_count[15:0].
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [15:0]                     req_tdata,
   // Result stream. tdata: brightness[7:0], filtered_lux[31:8].
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,
   // Configuration write port.
   input  logic                            csr_we,
   input  logic [altb_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [altb_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // Average width (Q16.F), log width and the division remainder width.
   localparam int AVG_W   = 16 + LUX_FRAC_BITS;
   localparam int LOG_W   = $clog2(AVG_W) + 16;
   localparam int SUM_W   = AVG_W + 17;
   localparam int REM_W   = LOG_W + altb_pkg::QUOT_W;
   localparam int Y_W     = 18 + LUX_FRAC_BITS;
   localparam int MUL_W   = altb_pkg::MUL_W;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int CNT_W   = $clog2(altb_pkg::QUOT_W);

   // Configuration registers.
   logic [16:0] alpha_ff;
   logic [15:0] min_ff, max_ff;
   logic [7:0]  floor_ff, cap_ff;

   // Sequencer and datapath registers.
   altb_pkg::state_type state_ff, state_in;
   logic [15:0]               raw_ff, raw_in;
   logic [AVG_W-1:0]          sample_ff, sample_in;
   logic [AVG_W-1:0]          avg_ff, avg_in;
   logic [SUM_W-1:0]          acc_ff, acc_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [LOG_W-1:0]          lmin_ff, lmin_in;
   logic [LOG_W-1:0]          lmax_ff, lmax_in;
   logic [LOG_W-1:0]          lv_ff, lv_in;
   logic [REM_W-1:0]          dsh_ff, dsh_in;
   logic [altb_pkg::QUOT_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [31:0]               rsp_data_ff, rsp_data_in;

   // Shared multiplier and log2 unit hookup.
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] mul_p;
   logic              log_start;
   logic [AVG_W-1:0]  log_value;
   logic              log_done;
   logic [LOG_W-1:0]  log_result;

   // Derived values.
   logic [16:0]       alpha_c;
   logic [15:0]       lo_c;
   logic [AVG_W-1:0]  lo_q, hi_q, v_c;
   logic [18:0]       raw5;
   logic [Y_W-1:0]    y_c;
   logic [AVG_W-1:0]  sample_c;
   logic [SUM_W-1:0]  sum_c;
   logic [LOG_W-1:0]  den_c, num_c;
   logic [7:0]        range_c;
   logic [REM_W-1:0]  rem_c;
   logic              map_ok;
   logic [8:0]        bright_sum;
   logic [7:0]        bright_c;
   logic [AVG_W+23:0] avg_wide;
   logic              out_free;
   logic              req_accept;

   // ------------------------------------------------------------------------
   // Configuration. User must write only while the block is idle; not checked.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= altb_pkg::ALPHA_RESET;
         min_ff   <= altb_pkg::MIN_RESET;
         max_ff   <= altb_pkg::MAX_RESET;
         floor_ff <= altb_pkg::FLOOR_RESET;
         cap_ff   <= altb_pkg::CAP_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            altb_pkg::CSR_FILTER_ALPHA:     alpha_ff <= csr_wdata;
            altb_pkg::CSR_MIN_LUX:          min_ff   <= csr_wdata[15:0];
            altb_pkg::CSR_MAX_LUX:          max_ff   <= csr_wdata[15:0];
            altb_pkg::CSR_BRIGHTNESS_FLOOR: floor_ff <= csr_wdata[7:0];
            altb_pkg::CSR_BRIGHTNESS_CAP:   cap_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // An alpha above one acts as one, and a zero minimum acts as one lux.
   assign alpha_c = (alpha_ff > altb_pkg::ALPHA_ONE) ? altb_pkg::ALPHA_ONE : alpha_ff;
   assign lo_c    = (min_ff == '0) ? 16'd1 : min_ff;
   assign lo_q    = {lo_c, {LUX_FRAC_BITS{1'b0}}};
   assign hi_q    = {max_ff, {LUX_FRAC_BITS{1'b0}}};

   // Clamp the fresh average into the lux window before its log is taken.
   always_comb begin
      v_c = avg_ff;
      if (v_c < lo_q) v_c = lo_q;
      if (v_c > hi_q) v_c = hi_q;
   end

   // raw/1.2 = floor(raw*5*2^F / 6) = floor(floor(raw*5*2^F / 2) / 3),
   // where the divide by three is a multiply by the reciprocal.
   assign raw5     = {3'b000, raw_ff} + {1'b0, raw_ff, 2'b00};
   assign y_c      = {raw5, {(LUX_FRAC_BITS-1){1'b0}}};
   assign sample_c = prod_ff[altb_pkg::RECIP3_SHIFT +: AVG_W];
   assign sum_c    = acc_ff + prod_ff[SUM_W-1:0];

   // Log mapping terms. The position within the window is clamped to it.
   assign den_c   = lmax_ff - lmin_ff;
   assign range_c = cap_ff - floor_ff;
   always_comb begin
      num_c = (lv_ff > lmin_ff) ? (lv_ff - lmin_ff) : '0;
      if (num_c > den_c) num_c = den_c;
   end
   assign rem_c  = prod_ff[REM_W-1:0];
   assign map_ok = (max_ff > lo_c) && (cap_ff > floor_ff) && (lmax_ff > lmin_ff);

   assign bright_sum = {1'b0, floor_ff} + {1'b0, quot_ff};
   always_comb begin
      if (!map_ok) begin
         bright_c = floor_ff;
      end else if (bright_sum > {1'b0, cap_ff}) begin
         bright_c = cap_ff;
      end else begin
         bright_c = bright_sum[7:0];
      end
   end

   assign avg_wide   = {24'd0, avg_ff};
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // ------------------------------------------------------------------------
   // Shared units.
   // ------------------------------------------------------------------------
   assign mul_p = mul_a * mul_b;

   altb_log2 #(
      .VALUE_W    (AVG_W),
      .TABLE_BITS (LOG_TABLE_BITS)
   ) u_log2 (
      .clock   (clock),
      .reset   (reset),
      .start_i (log_start),
      .value_i (log_value),
      .done_o  (log_done),
      .log_o   (log_result)
   );

   // ------------------------------------------------------------------------
   // Sequencer: next state.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         altb_pkg::ST_IDLE:      if (req_accept) state_in = altb_pkg::ST_RECIP;
         altb_pkg::ST_RECIP:     state_in = altb_pkg::ST_MUL_NEW;
         altb_pkg::ST_MUL_NEW:   state_in = altb_pkg::ST_MUL_OLD;
         altb_pkg::ST_MUL_OLD:   state_in = altb_pkg::ST_EMA;
         altb_pkg::ST_EMA:       state_in = altb_pkg::ST_LOG_LO;
         altb_pkg::ST_LOG_LO:    if (log_done) state_in = altb_pkg::ST_LOG_HI;
         altb_pkg::ST_LOG_HI:    if (log_done) state_in = altb_pkg::ST_LOG_V;
         altb_pkg::ST_LOG_V:     if (log_done) state_in = altb_pkg::ST_MUL_RANGE;
         altb_pkg::ST_MUL_RANGE: state_in = altb_pkg::ST_DIV;
         altb_pkg::ST_DIV:       if (cnt_ff == '0) state_in = altb_pkg::ST_OUT;
         altb_pkg::ST_OUT:       if (out_free) state_in = altb_pkg::ST_IDLE;
         default:                state_in = altb_pkg::ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer: unit controls.
   // ------------------------------------------------------------------------
   always_comb begin
      mul_a      = '0;
      mul_b      = '0;
      log_start  = 1'b0;
      log_value  = lo_q;
      req_tready = 1'b0;
      case (state_ff)
         altb_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         altb_pkg::ST_RECIP: begin
            mul_a = MUL_W'(y_c);
            mul_b = altb_pkg::RECIP3;
         end
         altb_pkg::ST_MUL_NEW: begin
            mul_a = MUL_W'(alpha_c);
            mul_b = MUL_W'(sample_c);
         end
         altb_pkg::ST_MUL_OLD: begin
            // An unseeded average takes the sample itself.
            mul_a = MUL_W'(altb_pkg::ALPHA_ONE - alpha_c);
            mul_b = (avg_ff == '0) ? MUL_W'(sample_ff) : MUL_W'(avg_ff);
         end
         altb_pkg::ST_EMA: begin
            log_start = 1'b1;
            log_value = lo_q;
         end
         altb_pkg::ST_LOG_LO: begin
            log_start = log_done;
            log_value = hi_q;
         end
         altb_pkg::ST_LOG_HI: begin
            log_start = log_done;
            log_value = v_c;
         end
         altb_pkg::ST_MUL_RANGE: begin
            mul_a = MUL_W'(num_c);
            mul_b = MUL_W'(range_c);
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath next values.
   // ------------------------------------------------------------------------
   always_comb begin
      raw_in       = raw_ff;
      sample_in    = sample_ff;
      avg_in       = avg_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      lmin_in      = lmin_ff;
      lmax_in      = lmax_ff;
      lv_in        = lv_ff;
      dsh_in       = dsh_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         altb_pkg::ST_IDLE: begin
            if (req_accept) raw_in = req_tdata;
         end
         altb_pkg::ST_RECIP: begin
            prod_in = mul_p;
         end
         altb_pkg::ST_MUL_NEW: begin
            sample_in = sample_c;
            prod_in   = mul_p;
         end
         altb_pkg::ST_MUL_OLD: begin
            acc_in  = prod_ff[SUM_W-1:0] + SUM_W'(altb_pkg::EMA_HALF);
            prod_in = mul_p;
         end
         altb_pkg::ST_EMA: begin
            avg_in = sum_c[16 +: AVG_W];
         end
         altb_pkg::ST_LOG_LO: begin
            if (log_done) lmin_in = log_result;
         end
         altb_pkg::ST_LOG_HI: begin
            if (log_done) lmax_in = log_result;
         end
         altb_pkg::ST_LOG_V: begin
            if (log_done) lv_in = log_result;
         end
         altb_pkg::ST_MUL_RANGE: begin
            prod_in = mul_p;
            dsh_in  = REM_W'({den_c, {(altb_pkg::QUOT_W-1){1'b0}}});
            quot_in = '0;
            cnt_in  = CNT_W'(altb_pkg::QUOT_W - 1);
         end
         altb_pkg::ST_DIV: begin
            // Restoring division, one quotient bit per step; the product
            // register holds the running remainder.
            if (rem_c >= dsh_ff) begin
               prod_in = PROD_W'(rem_c - dsh_ff);
               quot_in = {quot_ff[altb_pkg::QUOT_W-2:0], 1'b1};
            end else begin
               quot_in = {quot_ff[altb_pkg::QUOT_W-2:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
         end
         altb_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {avg_wide[23:0], bright_c};
            end
         end
         default: ;
      endcase
   end

   // Control state, the running average and the output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= altb_pkg::ST_IDLE;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      raw_ff      <= raw_in;
      sample_ff   <= sample_in;
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      lmin_ff     <= lmin_in;
      lmax_ff     <= lmax_in;
      lv_ff       <= lv_in;
      dsh_ff      <= dsh_in;
      quot_ff     <= quot_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   a_log_in_seq: assert property (@(posedge clock) disable iff (reset)
      log_done |-> (state_ff == altb_pkg::ST_LOG_LO || state_ff == altb_pkg::ST_LOG_HI ||
                    state_ff == altb_pkg::ST_LOG_V))
      else $error("log2 result outside a log step");

   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == altb_pkg::ST_OUT && map_ok) |-> quot_ff <= range_c)
      else $error("brightness quotient above the brightness range");

   a_bright_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == altb_pkg::ST_OUT) |-> bright_c >= floor_ff)
      else $error("brightness below floor");

   a_avg_seeded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == altb_pkg::ST_EMA && sample_ff != '0) |=> avg_ff != '0)
      else $error("average left unseeded after a nonzero sample");

endmodule

FILE: sim/brightness_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brightness_checker
// Watches the sensor, result and register ports of the lux-to-brightness
// block, predicts every result word and compares it as it is accepted.
// ----------------------------------------------------------------------------
module brightness_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [15:0]                     req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [31:0]                     rsp_tdata,
   input  logic                            csr_we,
   input  logic [altb_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [altb_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              results_owed
);

   localparam int FRAC   = altb_pkg::LUX_FRAC_BITS;
   localparam int TBITS  = altb_pkg::LOG_TABLE_BITS;
   localparam int AVG_W  = 16 + FRAC;

   typedef struct packed {
      logic [7:0]  brightness;
      logic [23:0] filtered_lux;
   } lux_result_type;

   // Mirror of the register file and of the smoothed lux value.
   logic [16:0]     cfg_alpha;
   logic [15:0]     cfg_min;
   logic [15:0]     cfg_max;
   logic [7:0]      cfg_floor;
   logic [7:0]      cfg_cap;
   longint unsigned avg_lux;

   logic [15:0]    frac_lut [0:(1 << TBITS) - 1];
   lux_result_type brightness_due [$];
   lux_result_type want;

   // Fraction table, log2(1 + i/2^TBITS) in Q0.16, by repeated squaring.
   initial begin
      longint unsigned m;
      logic [15:0]     f;
      for (int i = 0; i < (1 << TBITS); i++) begin
         m = ((64'd1 << TBITS) + 64'(i)) << (30 - TBITS);
         f = '0;
         for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            f = {f[14:0], 1'b0};
            if (m >= (64'd1 << 31)) begin
               f[0] = 1'b1;
               m    = m >> 1;
            end
         end
         frac_lut[i] = f;
      end
   end

   function automatic longint unsigned log2_q16(input longint unsigned v);
      int unsigned     lead;
      longint unsigned idx;
      lead = 0;
      for (int b = 1; b < 64; b++)
         if (v[b]) lead = b;
      if (lead >= TBITS)
         idx = (v >> (lead - TBITS)) & ((64'd1 << TBITS) - 1);
      else
         idx = (v << (TBITS - lead)) & ((64'd1 << TBITS) - 1);
      return (64'(lead) << 16) + 64'(frac_lut[idx]);
   endfunction

   // Advances the moving average by one count and maps it to a brightness.
   function automatic lux_result_type smooth_and_map(input logic [15:0] raw);
      longint unsigned sample, alpha, lo, hi, lo_q, hi_q, v;
      longint unsigned lmin, lmax, lv, num, den, bright, b_floor, b_cap;
      lux_result_type  r;
      sample  = 64'(raw);
      sample  = ((sample * 5) << FRAC) / 6;
      alpha   = (cfg_alpha > altb_pkg::ALPHA_ONE) ? 64'(altb_pkg::ALPHA_ONE)
                                                  : 64'(cfg_alpha);
      lo      = (cfg_min == '0) ? 64'd1 : 64'(cfg_min);
      hi      = 64'(cfg_max);
      b_floor = 64'(cfg_floor);
      b_cap   = 64'(cfg_cap);
      bright  = b_floor;

      if (avg_lux == 0)
         avg_lux = sample;
      avg_lux = alpha * sample + (64'(altb_pkg::ALPHA_ONE) - alpha) * avg_lux
                + 64'(altb_pkg::EMA_HALF);
      avg_lux = (avg_lux >> 16) & ((64'd1 << AVG_W) - 1);

      if (hi > lo && b_cap > b_floor) begin
         lo_q = lo << FRAC;
         hi_q = hi << FRAC;
         v    = avg_lux;
         if (v < lo_q) v = lo_q;
         if (v > hi_q) v = hi_q;
         lmin = log2_q16(lo_q);
         lmax = log2_q16(hi_q);
         lv   = log2_q16(v);
         if (lmax > lmin) begin
            den = lmax - lmin;
            num = (lv > lmin) ? lv - lmin : 64'd0;
            if (num > den) num = den;
            bright = b_floor + (num * (b_cap - b_floor)) / den;
            if (bright > b_cap) bright = b_cap;
         end
      end

      r.brightness   = bright[7:0];
      r.filtered_lux = avg_lux[23:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg_alpha = altb_pkg::ALPHA_RESET;
         cfg_min   = altb_pkg::MIN_RESET;
         cfg_max   = altb_pkg::MAX_RESET;
         cfg_floor = altb_pkg::FLOOR_RESET;
         cfg_cap   = altb_pkg::CAP_RESET;
         avg_lux   = 0;
         brightness_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               altb_pkg::CSR_FILTER_ALPHA:     cfg_alpha = csr_wdata[16:0];
               altb_pkg::CSR_MIN_LUX:          cfg_min   = csr_wdata[15:0];
               altb_pkg::CSR_MAX_LUX:          cfg_max   = csr_wdata[15:0];
               altb_pkg::CSR_BRIGHTNESS_FLOOR: cfg_floor = csr_wdata[7:0];
               altb_pkg::CSR_BRIGHTNESS_CAP:   cfg_cap   = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            brightness_due.push_back(smooth_and_map(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (brightness_due.size() == 0) begin
               $display("%0t: result word %h with none expected", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = brightness_due.pop_front();
               if (rsp_tdata[7:0] !== want.brightness) begin
                  $display("%0t: brightness expected %0d, got %0d",
                           $time, want.brightness, rsp_tdata[7:0]);
                  fail_count++;
               end
               if (rsp_tdata[31:8] !== want.filtered_lux) begin
                  $display("%0t: filtered_lux expected %h, got %h",
                           $time, want.filtered_lux, rsp_tdata[31:8]);
                  fail_count++;
               end
            end
         end
      end
      results_owed = brightness_due.size();
   end

endmodule

FILE: sim/tb_ambient_lux_to_brightness.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ambient_lux_to_brightness
// Drives sensor counts and register settings into the lux-to-brightness block
// under varied handshake pressure; a checker beside the block predicts and
// compares every result word, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_ambient_lux_to_brightness;

   // The block takes a word only after the last is through; let it settle
   // before touching the registers once the last result is out.
   localparam int SETTLE_CYCLES   = 40;
   localparam int RAND_PHASES     = 8;
   localparam int ITEMS_PER_PHASE = 205;
   localparam int HOLDOFF_CYCLES  = 400;
   localparam int TIMEOUT_NS      = 5_000_000;
   localparam int ADDR_W          = altb_pkg::CSR_ADDR_W;
   localparam int DATA_W          = altb_pkg::CSR_DATA_W;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [15:0]       req_tdata;   // raw_count[15:0]
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [31:0]       rsp_tdata;   // brightness[7:0], filtered_lux[31:8]
   logic              csr_we;
   logic [ADDR_W-1:0] csr_addr;
   logic [DATA_W-1:0] csr_wdata;

   int fail_count;
   int results_owed;

   // Handshake pressure knobs, in percent of cycles. Each bump of the
   // hold-off request asks the result side for one long stall.
   int src_idle_pct;
   int sink_stall_pct;
   int holdoff_req;

   ambient_lux_to_brightness dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   brightness_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Result side. Normally ready is drawn per cycle from the stall rate. When
   // a hold-off is requested, ready stays low for a long counted stretch so
   // the block backs up and stops taking words.
   initial begin
      int holdoff_seen;
      holdoff_seen = 0;
      rsp_tready   = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_req != holdoff_seen) begin
            holdoff_seen = holdoff_req;
            rsp_tready <= 1'b0;
            repeat (HOLDOFF_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   // Offers one sensor word, with random idle cycles ahead of it, and returns
   // right after the rising edge at which the block takes it. Valid is left
   // high so back-to-back words need no extra assignment.
   task automatic send_count(input logic [15:0] raw);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= raw;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering words and waits until every predicted result has come
   // back, then lets the block settle.
   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
   endtask

   // Writes the whole register set; only called while the block is idle.
   task automatic load_settings(input logic [16:0] alpha,
                                input logic [15:0] lo,
                                input logic [15:0] hi,
                                input logic [7:0]  b_floor,
                                input logic [7:0]  b_cap);
      write_reg(altb_pkg::CSR_FILTER_ALPHA, DATA_W'(alpha));
      write_reg(altb_pkg::CSR_MIN_LUX, DATA_W'(lo));
      write_reg(altb_pkg::CSR_MAX_LUX, DATA_W'(hi));
      write_reg(altb_pkg::CSR_BRIGHTNESS_FLOOR, DATA_W'(b_floor));
      write_reg(altb_pkg::CSR_BRIGHTNESS_CAP, DATA_W'(b_cap));
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [16:0] alpha;
      int          lo, hi, b_floor, b_cap;
      int          pick, sent, span, level, jitter, val;

      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_we         = 1'b0;
      csr_addr       = '0;
      csr_wdata      = '0;
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Reset settings. The first word seeds the unseeded average; 1200
      // counts is exactly the default top of the range.
      send_count(16'd1200);
      send_count(16'd0);
      send_count(16'd65535);
      send_count(16'd1);
      send_count(16'd6);
      wait_for_results();

      // Full weight on the new sample, so the average follows the input and
      // drops to zero on a zero count; the next count then reseeds it. A zero
      // minimum is taken as one, and the brightness span is the widest.
      load_settings(altb_pkg::ALPHA_ONE, 16'd0, 16'd65535, 8'd0, 8'd255);
      send_count(16'd0);
      send_count(16'd1);
      send_count(16'd0);
      send_count(16'd65535);
      send_count(16'h5555);
      send_count(16'hAAAA);
      send_count(16'd1200);
      send_count(16'd12);
      wait_for_results();

      // Weight above one is limited to one; maximum below minimum gives the
      // floor.
      load_settings(17'h1FFFF, 16'd65535, 16'd500, 8'd20, 8'd200);
      send_count(16'd300);
      send_count(16'd65535);
      wait_for_results();

      // Zero weight freezes the average.
      load_settings(17'd0, 16'd10, 16'd2000, 8'd5, 8'd250);
      send_count(16'd0);
      send_count(16'd65535);
      wait_for_results();

      // Cap below floor gives the floor.
      load_settings(altb_pkg::ALPHA_ONE, 16'd1, 16'd1000, 8'd200, 8'd100);
      send_count(16'd600);
      send_count(16'd60);
      wait_for_results();

      // Bounds 1000 and 1001 land on the same table entry, so the two logs
      // are equal and the floor is given.
      load_settings(17'd40000, 16'd1000, 16'd1001, 8'd0, 8'd255);
      send_count(16'd1200);
      send_count(16'd1201);
      wait_for_results();

      // Both bounds zero: minimum becomes one, maximum is not above it.
      load_settings(altb_pkg::ALPHA_ONE, 16'd0, 16'd0, 8'd77, 8'd255);
      send_count(16'd5);
      wait_for_results();

      // Random phases. Counts come in runs around a level spread over all
      // magnitudes, so the average settles at low, middle and high lux, with
      // one word in ten of pure noise.
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         pick = $urandom_range(9);
         if (pick == 0)
            alpha = altb_pkg::ALPHA_ONE;
         else if (pick == 1)
            alpha = 17'($urandom_range(131071, 65537));
         else if (pick == 2)
            alpha = 17'($urandom_range(255, 1));
         else
            alpha = 17'($urandom_range(65535, 256));

         if ($urandom_range(9) == 0) begin
            lo = $urandom_range(65535);
            hi = $urandom_range(lo);
         end else begin
            lo = $urandom_range(3000);
            hi = $urandom_range(65535, lo + 1);
         end

         if ($urandom_range(9) == 0) begin
            b_floor = $urandom_range(255);
            b_cap   = $urandom_range(b_floor);
         end else begin
            b_floor = $urandom_range(128);
            b_cap   = $urandom_range(255, b_floor + 1);
         end
         load_settings(alpha, lo[15:0], hi[15:0], b_floor[7:0], b_cap[7:0]);

         case (ph % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 46; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 46; end
            default: begin src_idle_pct = 33; sink_stall_pct = 33; end
         endcase

         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            span   = $urandom_range(40, 4);
            level  = $urandom & ((1 << $urandom_range(16)) - 1);
            jitter = level >> 3;
            for (int n = 0; n < span && sent < ITEMS_PER_PHASE; n++) begin
               if ($urandom_range(9) == 0)
                  val = $urandom_range(65535);
               else
                  val = level - jitter + $urandom_range(2 * jitter);
               if (val > 65535) val = 65535;

               // A long result-side hold-off while words keep coming, and
               // later a pause until everything owed is back.
               if (ph == 2 && sent == 60)
                  holdoff_req++;
               if (ph == 5 && sent == 100)
                  wait_for_results();

               send_count(val[15:0]);
               sent++;
            end
         end
         wait_for_results();
      end

      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("status: fail");
      $finish;
   end

endmodule

FILE: ambient_lux_to_brightness.f
rtl/core/altb_pkg.sv
rtl/core/altb_log2.sv
rtl/core/ambient_lux_to_brightness.sv
sim/brightness_checker.sv
sim/tb_ambient_lux_to_brightness.sv
